@@ src/elpo_pkg.sv @@
// ----------------------------------------------------------------------------
// elpo_pkg: shared constants for the encoder line parser with odometry
// Register indexes, reset values, field widths and the fixed-point constants
// used by the odometry back end.
// ----------------------------------------------------------------------------
package elpo_pkg;

	// default width of a parsed encoder count
	localparam int COUNT_BITS_DEF = 32;
	// depth of the line record queue between parser and odometry unit
	localparam int FIFO_DEPTH_DEF = 4;

	// configuration port
	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_CPR           = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_L         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_R         = 3'd3;
	localparam logic [CFG_W-1:0] CPR_RESET    = 20'd4096;
	localparam logic [CFG_W-1:0] PERIOD_RESET = 20'd10000;

	// result widths
	localparam int POS_W = 48;
	localparam int VEL_W = 32;

	// 2*pi in Q32, and 2*pi in Q32 scaled by one million (us to s)
	localparam int K_W  = 35;
	localparam int KM_W = 55;
	localparam logic [K_W-1:0]  TWO_PI_Q32      = 35'h6487ED511;
	localparam logic [KM_W-1:0] TWO_PI_MEGA_Q32 = 55'(64'h6487ED511 * 64'd1000000);

	// divisors: counts per rev << 16 and counts per rev * period << 16
	localparam int D1_W = CFG_W + 16;
	localparam int D2_W = 2 * CFG_W + 16;

endpackage

@@ src/encoder_line_parser_odometry.sv @@
// ----------------------------------------------------------------------------
// encoder_line_parser_odometry: serial encoder line parser with odometry
// Path: a result follows its newline transfer through the line queue, then
//   per wheel the shift-add multiply and the bit-serial divide, and then
//   the output register.
// Throughput: one byte per cycle unless in_stall; the odometry unit takes
//   one line record at a time, four records queue between the two.
// Reset: asynchronous, clears parser, odometry state and config to defaults.
// ----------------------------------------------------------------------------
module encoder_line_parser_odometry #(
	parameter int COUNT_BITS = elpo_pkg::COUNT_BITS_DEF,
	parameter int FIFO_DEPTH = elpo_pkg::FIFO_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           rx_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [elpo_pkg::POS_W-1:0]     left_position,
	output logic signed [elpo_pkg::POS_W-1:0]     right_position,
	output logic signed [elpo_pkg::VEL_W-1:0]     left_velocity,
	output logic signed [elpo_pkg::VEL_W-1:0]     right_velocity,
	input  logic                                 cfg_we,
	input  logic [elpo_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [elpo_pkg::CFG_W-1:0]            cfg_data
);
	import elpo_pkg::*;

	logic [CFG_W-1:0]      cpr_q, period_q;
	logic                  inv_l_q, inv_r_q;
	logic                  push_valid, push_stall, rec_valid, rec_stall;
	logic [2*COUNT_BITS-1:0] push_data, rec_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q    <= CPR_RESET;
			period_q <= PERIOD_RESET;
			inv_l_q  <= 1'b0;
			inv_r_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CPR:           cpr_q    <= cfg_data;
				CFG_UPDATE_PERIOD: period_q <= cfg_data;
				CFG_INV_L:         inv_l_q  <= cfg_data[0];
				CFG_INV_R:         inv_r_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	elpo_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.inv_left   (inv_l_q),
		.inv_right  (inv_r_q),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  (push_data)
	);

	elpo_fifo #(.WIDTH(2 * COUNT_BITS), .DEPTH(FIFO_DEPTH)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_stall (push_stall),
		.wr_data  (push_data),
		.rd_valid (rec_valid),
		.rd_stall (rec_stall),
		.rd_data  (rec_data)
	);

	elpo_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.rec_valid        (rec_valid),
		.rec_stall        (rec_stall),
		.rec_data         (rec_data),
		.cpr              (cpr_q),
		.update_period_us (period_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.left_position    (left_position),
		.right_position   (right_position),
		.left_velocity    (left_velocity),
		.right_velocity   (right_velocity)
	);

endmodule

@@ src/elpo_front.sv @@
// ----------------------------------------------------------------------------
// elpo_front: line parser
// Takes one byte per transfer, tracks the "C left right" grammar and pushes
// the (possibly inverted) left and right counts of every good line.
// ----------------------------------------------------------------------------
module elpo_front #(
	parameter int COUNT_BITS = elpo_pkg::COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              rx_byte,
	input  logic                    inv_left,
	input  logic                    inv_right,
	output logic                    push_valid,
	input  logic                    push_stall,
	output logic [2*COUNT_BITS-1:0] push_data
);
	import elpo_pkg::*;

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_PRE_L  = 3'd1;
	localparam logic [2:0] PH_SIGN_L = 3'd2;
	localparam logic [2:0] PH_DIG_L  = 3'd3;
	localparam logic [2:0] PH_PRE_R  = 3'd4;
	localparam logic [2:0] PH_SIGN_R = 3'd5;
	localparam logic [2:0] PH_DIG_R  = 3'd6;
	localparam logic [2:0] PH_TAIL   = 3'd7;

	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int EXT_W = COUNT_BITS + 4;

	logic [2:0]            phase_q, phase_d;
	logic [COUNT_BITS-1:0] accum_q, accum_d;
	logic                  neg_q, neg_d;
	logic [COUNT_BITS-1:0] left_q, left_d;
	logic                  bad_q, bad_d;

	logic                  accept;
	logic                  is_dig, is_sp, is_sign;
	logic [3:0]            digit;
	logic [EXT_W-1:0]      acc_ext, limit;
	logic                  digit_ovf;
	logic [COUNT_BITS-1:0] value, left_out, right_out;

	assign in_stall = push_stall;
	assign accept   = in_valid && !in_stall;

	// byte classes
	assign is_dig  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign is_sp   = (rx_byte == 8'h20) || (rx_byte == 8'h09) || (rx_byte == 8'h0B) ||
	                 (rx_byte == 8'h0C) || (rx_byte == 8'h0D);
	assign is_sign = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
	assign digit   = 4'(rx_byte - CH_ZERO);

	// accum*10 + digit against the signed range limit
	assign acc_ext   = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1) + EXT_W'(digit);
	assign limit     = {4'b0, neg_q, {(COUNT_BITS-1){!neg_q}}};
	assign digit_ovf = acc_ext > limit;

	assign value     = neg_q ? -accum_q : accum_q;
	assign left_out  = inv_left  ? -left_q : left_q;
	assign right_out = inv_right ? -value  : value;
	assign push_data = {left_out, right_out};

	// next parser state
	always_comb begin
		phase_d    = phase_q;
		accum_d    = accum_q;
		neg_d      = neg_q;
		left_d     = left_q;
		bad_d      = bad_q;
		push_valid = 1'b0;
		if (accept) begin
			if (rx_byte == CH_NL) begin
				push_valid = !bad_q && (phase_q == PH_DIG_R || phase_q == PH_TAIL);
				phase_d    = PH_START;
				accum_d    = '0;
				neg_d      = 1'b0;
				bad_d      = 1'b0;
			end else begin
				case (phase_q)
					PH_START: begin
						if (rx_byte == CH_C) begin
							phase_d = PH_PRE_L;
						end else begin
							bad_d   = 1'b1;
							phase_d = PH_TAIL;
						end
					end
					PH_PRE_L, PH_PRE_R, PH_DIG_L: begin
						if (phase_q == PH_DIG_L && is_dig) begin
							if (digit_ovf) begin
								bad_d   = 1'b1;
								phase_d = PH_TAIL;
							end else begin
								accum_d = acc_ext[COUNT_BITS-1:0];
							end
						end else begin
							// start of a count (after the left count ends, for the right one)
							if (phase_q == PH_DIG_L) begin
								left_d  = value;
								phase_d = PH_PRE_R;
							end
							accum_d = '0;
							neg_d   = 1'b0;
							if (is_sign) begin
								neg_d   = (rx_byte == CH_MINUS);
								phase_d = (phase_q == PH_PRE_L) ? PH_SIGN_L : PH_SIGN_R;
							end else if (is_dig) begin
								accum_d = COUNT_BITS'(digit);
								phase_d = (phase_q == PH_PRE_L) ? PH_DIG_L : PH_DIG_R;
							end else if (!is_sp) begin
								bad_d   = 1'b1;
								phase_d = PH_TAIL;
							end
						end
					end
					PH_SIGN_L, PH_SIGN_R: begin
						if (is_dig) begin
							accum_d = COUNT_BITS'(digit);
							phase_d = (phase_q == PH_SIGN_L) ? PH_DIG_L : PH_DIG_R;
						end else begin
							bad_d   = 1'b1;
							phase_d = PH_TAIL;
						end
					end
					PH_DIG_R: begin
						if (is_dig) begin
							if (digit_ovf) begin
								bad_d   = 1'b1;
								phase_d = PH_TAIL;
							end else begin
								accum_d = acc_ext[COUNT_BITS-1:0];
							end
						end else begin
							phase_d = PH_TAIL;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			accum_q <= '0;
			neg_q   <= 1'b0;
			left_q  <= '0;
			bad_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			neg_q   <= neg_d;
			left_q  <= left_d;
			bad_q   <= bad_d;
		end
	end

endmodule

@@ src/elpo_fifo.sv @@
// ----------------------------------------------------------------------------
// elpo_fifo: line record queue
// Small register queue that decouples the parser from the odometry unit.
// ----------------------------------------------------------------------------
module elpo_fifo #(
	parameter int WIDTH = 2 * elpo_pkg::COUNT_BITS_DEF,
	parameter int DEPTH = elpo_pkg::FIFO_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_stall,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_stall,
	output logic [WIDTH-1:0] rd_data
);
	import elpo_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             wr_en, rd_en;

	assign wr_stall = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign wr_en    = wr_valid && !wr_stall;
	assign rd_en    = rd_valid && !rd_stall;

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/elpo_back.sv @@
// ----------------------------------------------------------------------------
// elpo_back: odometry unit
// Turns each line record into wheel deltas, then per wheel a shift-add
// multiply and a bit-serial restoring divide give the angle step and the
// velocity; results leave through an output register.
// ----------------------------------------------------------------------------
module elpo_back #(
	parameter int COUNT_BITS = elpo_pkg::COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rec_valid,
	output logic                      rec_stall,
	input  logic [2*COUNT_BITS-1:0]   rec_data,
	input  logic [elpo_pkg::CFG_W-1:0] cpr,
	input  logic [elpo_pkg::CFG_W-1:0] update_period_us,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [elpo_pkg::POS_W-1:0] left_position,
	output logic signed [elpo_pkg::POS_W-1:0] right_position,
	output logic signed [elpo_pkg::VEL_W-1:0] left_velocity,
	output logic signed [elpo_pkg::VEL_W-1:0] right_velocity
);
	import elpo_pkg::*;

	localparam int W1    = COUNT_BITS + K_W;
	localparam int W2    = COUNT_BITS + KM_W;
	localparam int CNT_W = $clog2(W2 + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SETUP = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_RND   = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_UPD   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	localparam logic [VEL_W-1:0] VEL_POS_MAX = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic [VEL_W-1:0] VEL_NEG_MAX = {1'b1, {(VEL_W-1){1'b0}}};

	logic [2:0]            state_q;
	logic                  seen_q, sel_q;
	logic [COUNT_BITS-1:0] cur_l_q, cur_r_q, prev_l_q, prev_r_q;
	logic [POS_W-1:0]      ang_l_q, ang_r_q;
	logic [VEL_W-1:0]      vel_l_q, vel_r_q;
	logic [COUNT_BITS-1:0] mag_q;
	logic                  neg_q;
	logic [W1-1:0]         mc1_q, acc1_q;
	logic [W2-1:0]         mc2_q, acc2_q, num1_q, num2_q;
	logic [D1_W-1:0]       rem1_q;
	logic [D2_W-1:0]       rem2_q;
	logic [POS_W-1:0]      q1_q;
	logic [VEL_W-1:0]      q2_q;
	logic                  ovf_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [2*CFG_W-1:0]    cp_q;
	logic                  oval_q;
	logic [POS_W-1:0]      opos_l_q, opos_r_q;
	logic [VEL_W-1:0]      ovel_l_q, ovel_r_q;

	logic                  rec_take;
	logic [CFG_W-1:0]      c_eff, p_eff;
	logic [D1_W-1:0]       d1;
	logic [D2_W-1:0]       d2;
	logic [COUNT_BITS-1:0] delta, mag;
	logic [D1_W:0]         r1s, r1n;
	logic [D2_W:0]         r2s, r2n;
	logic                  ge1, ge2;
	logic [POS_W-1:0]      ang_sel, ang_new;
	logic [VEL_W-1:0]      lim, vmag, vel_new;

	assign rec_stall = (state_q != S_IDLE);
	assign rec_take  = rec_valid && !rec_stall;

	// zero settings act as one
	assign c_eff = (cpr == '0)              ? CFG_W'(1) : cpr;
	assign p_eff = (update_period_us == '0) ? CFG_W'(1) : update_period_us;
	assign d1    = {c_eff, 16'b0};
	assign d2    = {cp_q, 16'b0};

	// delta of the selected wheel, split into sign and magnitude
	assign delta = sel_q ? (cur_r_q - prev_r_q) : (cur_l_q - prev_l_q);
	assign mag   = delta[COUNT_BITS-1] ? -delta : delta;

	// one restoring divide step for each quotient
	assign r1s = {rem1_q, num1_q[W2-1]};
	assign ge1 = r1s >= {1'b0, d1};
	assign r1n = ge1 ? (r1s - {1'b0, d1}) : r1s;
	assign r2s = {rem2_q, num2_q[W2-1]};
	assign ge2 = r2s >= {1'b0, d2};
	assign r2n = ge2 ? (r2s - {1'b0, d2}) : r2s;

	// angle update and velocity saturation
	assign ang_sel = sel_q ? ang_r_q : ang_l_q;
	assign ang_new = neg_q ? (ang_sel - q1_q) : (ang_sel + q1_q);
	assign lim     = neg_q ? VEL_NEG_MAX : VEL_POS_MAX;
	assign vmag    = (ovf_q || (q2_q > lim)) ? lim : q2_q;
	assign vel_new = neg_q ? -vmag : vmag;

	// counts per rev * period, held for the velocity divisor
	always_ff @(posedge clk) begin
		cp_q <= c_eff * p_eff;
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			seen_q   <= 1'b0;
			sel_q    <= 1'b0;
			prev_l_q <= '0;
			prev_r_q <= '0;
			ang_l_q  <= '0;
			ang_r_q  <= '0;
			oval_q   <= 1'b0;
		end else begin
			// output register: load on the output step, clear once taken
			if (state_q == S_OUT && (!oval_q || !out_stall)) begin
				oval_q <= 1'b1;
			end else if (oval_q && !out_stall) begin
				oval_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (rec_take) begin
						cur_l_q <= rec_data[2*COUNT_BITS-1:COUNT_BITS];
						cur_r_q <= rec_data[COUNT_BITS-1:0];
						sel_q   <= 1'b0;
						if (!seen_q) begin
							// first line only latches the counts
							prev_l_q <= rec_data[2*COUNT_BITS-1:COUNT_BITS];
							prev_r_q <= rec_data[COUNT_BITS-1:0];
							seen_q   <= 1'b1;
						end else begin
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					neg_q   <= delta[COUNT_BITS-1];
					mag_q   <= mag;
					mc1_q   <= W1'(TWO_PI_Q32);
					mc2_q   <= W2'(TWO_PI_MEGA_Q32);
					acc1_q  <= '0;
					acc2_q  <= '0;
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mag_q[0]) begin
						acc1_q <= acc1_q + mc1_q;
						acc2_q <= acc2_q + mc2_q;
					end
					mag_q <= mag_q >> 1;
					mc1_q <= mc1_q << 1;
					mc2_q <= mc2_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(COUNT_BITS - 1)) begin
						state_q <= S_RND;
					end
				end
				S_RND: begin
					// add half the divisor for rounding half away from zero
					num1_q  <= W2'(acc1_q) + W2'({c_eff, 15'b0});
					num2_q  <= acc2_q + W2'({cp_q, 15'b0});
					rem1_q  <= '0;
					rem2_q  <= '0;
					q1_q    <= '0;
					q2_q    <= '0;
					ovf_q   <= 1'b0;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem1_q <= r1n[D1_W-1:0];
					rem2_q <= r2n[D2_W-1:0];
					q1_q   <= {q1_q[POS_W-2:0], ge1};
					q2_q   <= {q2_q[VEL_W-2:0], ge2};
					ovf_q  <= ovf_q | q2_q[VEL_W-1];
					num1_q <= num1_q << 1;
					num2_q <= num2_q << 1;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(W2 - 1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (sel_q) begin
						ang_r_q  <= ang_new;
						vel_r_q  <= vel_new;
						prev_r_q <= cur_r_q;
						state_q  <= S_OUT;
					end else begin
						ang_l_q  <= ang_new;
						vel_l_q  <= vel_new;
						prev_l_q <= cur_l_q;
						sel_q    <= 1'b1;
						state_q  <= S_SETUP;
					end
				end
				S_OUT: begin
					if (!oval_q || !out_stall) begin
						opos_l_q <= ang_l_q;
						opos_r_q <= ang_r_q;
						ovel_l_q <= vel_l_q;
						ovel_r_q <= vel_r_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = oval_q;
	assign left_position  = opos_l_q;
	assign right_position = opos_r_q;
	assign left_velocity  = ovel_l_q;
	assign right_velocity = ovel_r_q;

endmodule

@@ src/elpo_checker.sv @@
// ----------------------------------------------------------------------------
// elpo_checker: port-level checks for the encoder line parser
// Watches the top level's ports; bound to it below.
// ----------------------------------------------------------------------------
module elpo_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic [7:0]                       rx_byte,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [elpo_pkg::POS_W-1:0]        left_position,
	input logic [elpo_pkg::POS_W-1:0]        right_position,
	input logic [elpo_pkg::VEL_W-1:0]        left_velocity,
	input logic [elpo_pkg::VEL_W-1:0]        right_velocity
);
	import elpo_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(left_position) && $stable(right_position) &&
			$stable(left_velocity) && $stable(right_velocity))
		else $error("result payload changed while stalled");

	// handshake outputs are always known out of reset
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_stall, out_valid}))
		else $error("handshake output unknown");

	// reset leaves no result pending
	a_reset_clear: assert property (@(posedge clk)
		$past(!arst_n) |-> !out_valid)
		else $error("result valid out of reset");

endmodule

bind encoder_line_parser_odometry elpo_checker u_elpo_checker (.*);
